// ===== rtl/hvd_pkg.sv =====
package hvd_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int XY_W         = 34;

  // coordinate scaling: (|x| * 2^31 + 9e8) / 1.8e9 by reciprocal, then one correction
  localparam logic [31:0] SC_RECIP = 32'd2562047788;  // floor(2^62 / 1.8e9)
  localparam logic [30:0] SC_DIV   = 31'd1800000000;
  localparam logic [30:0] SC_HALF  = 31'd900000000;

  localparam int SQ_STEPS = 31;

  localparam logic signed [XY_W-1:0] CORD_GAIN = 34'sd652032874;
  localparam logic [30:0] ONE_Q30      = 31'd1073741824;
  localparam logic [30:0] PI_Q29       = 31'd1686629713;
  localparam logic [24:0] DIST_MAX     = 25'd25200000;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;

  typedef struct packed {
    logic                   valid;
    logic                   flip;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] z;
  } cordic_t;

  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] r;
    unique case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/hvd_cordic.sv =====
module hvd_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vect_i,
  input  hvd_pkg::cordic_t in_i,
  output hvd_pkg::cordic_t out_o
);

  localparam int N = hvd_pkg::CORDIC_STEPS;
  localparam int W = hvd_pkg::XY_W;

  logic                vld_q  [N+1];
  logic                flip_q [N+1];
  logic signed [W-1:0] x_q    [N+1];
  logic signed [W-1:0] y_q    [N+1];
  logic signed [W-1:0] z_q    [N+1];

  logic [31:0]         ang;
  logic                fold;
  logic signed [W-1:0] z0;

  // fold angles beyond a quarter turn by a half turn, negate the cosine later
  always_comb begin
    ang  = in_i.z[31:0];
    fold = !vect_i && (ang[31] ^ ang[30]);
    z0   = vect_i ? in_i.z : W'($signed(ang ^ {fold, 31'b0}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q[0] <= fold;
    x_q[0]    <= in_i.x;
    y_q[0]    <= in_i.y;
    z_q[0]    <= z0;
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic                up;
    logic signed [W-1:0] dx, dy, at, x_n, y_n, z_n;

    always_comb begin
      up  = vect_i ? (y_q[k-1] < 0) : (z_q[k-1] >= 0);
      dx  = y_q[k-1] >>> (k - 1);
      dy  = x_q[k-1] >>> (k - 1);
      at  = W'(hvd_pkg::atan_entry(k - 1));
      x_n = up ? x_q[k-1] - dx : x_q[k-1] + dx;
      y_n = up ? y_q[k-1] + dy : y_q[k-1] - dy;
      z_n = up ? z_q[k-1] - at : z_q[k-1] + at;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      flip_q[k] <= flip_q[k-1];
      x_q[k]    <= x_n;
      y_q[k]    <= y_n;
      z_q[k]    <= z_n;
    end
  end

  always_comb begin
    out_o.valid = vld_q[N];
    out_o.flip  = flip_q[N];
    out_o.x     = x_q[N];
    out_o.y     = y_q[N];
    out_o.z     = z_q[N];
  end

endmodule

// ===== rtl/haversine_distance_core.sv =====
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+---------------------------------------------
// command   | in        | start, busy         | start_lat_i, start_lon_i, dest_lat_i, dest_lon_i
// result    | out       | done_o              | distance_m_o
// config    | in        | cfg_we_i            | cfg_wdata_i (sphere radius, metres)
//
// One coordinate pair may enter every cycle; busy is never raised.
// A pair passes in order through the 6-stage coordinate scaling, the cosine
// CORDIC units, the 31-stage root and the vectoring CORDIC unit, all pipelined.
// Reset clears all valid bits and loads the default radius.
// The receiver cannot stall: done_o is a single-cycle strobe per transfer.
module haversine_distance_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic signed [30:0] start_lat_i,
  input  logic signed [31:0] start_lon_i,
  input  logic signed [30:0] dest_lat_i,
  input  logic signed [31:0] dest_lon_i,
  input  logic               cfg_we_i,
  input  logic        [22:0] cfg_wdata_i,
  output logic               busy,
  output logic               done_o,
  output logic        [24:0] distance_m_o
);

  localparam int SC  = 6;
  localparam int SQ  = hvd_pkg::SQ_STEPS;
  localparam int W   = hvd_pkg::XY_W;
  localparam int LAT = SC + 1 + (hvd_pkg::CORDIC_STEPS + 1) + 2 + (SQ + 1)
                       + (hvd_pkg::CORDIC_STEPS + 1) + 3;

  logic [22:0] radius_q;
  logic        take;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= hvd_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // ---------------- coordinate scaling: |x| * 2^31 / 1.8e9, rounded ----------------
  logic [31:0] coord [4];
  logic [31:0] mag   [4];
  logic [31:0] bam   [4];
  logic        sc_vld_q [SC];

  assign coord[0] = {start_lat_i[30], start_lat_i};
  assign coord[1] = start_lon_i;
  assign coord[2] = {dest_lat_i[30], dest_lat_i};
  assign coord[3] = dest_lon_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SC; s++) begin
        sc_vld_q[s] <= 1'b0;
      end
    end else begin
      sc_vld_q[0] <= take;
      for (int s = 1; s < SC; s++) begin
        sc_vld_q[s] <= sc_vld_q[s-1];
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [31:0] mag0_q, mag1_q, mag2_q, q0a_q, q0b_q, q0c_q, rem_q, quo_q;
    logic [63:0] prod_q, prod_rnd;
    logic [62:0] qd_q, num_q, diff;
    logic        neg_q [SC];

    assign mag[l]   = coord[l][31] ? (~coord[l] + 32'd1) : coord[l];
    // reciprocal estimate is exact or one short; the remainder decides the last step
    assign prod_rnd = prod_q + (64'd1 << 30);
    assign diff     = num_q - qd_q;
    assign bam[l]   = neg_q[SC-1] ? (32'd0 - quo_q) : quo_q;

    always_ff @(posedge clk_i) begin
      neg_q[0] <= coord[l][31];
      for (int s = 1; s < SC; s++) begin
        neg_q[s] <= neg_q[s-1];
      end
      mag0_q <= mag[l];
      prod_q <= 64'(mag0_q) * 64'(hvd_pkg::SC_RECIP);
      mag1_q <= mag0_q;
      q0a_q  <= prod_rnd[62:31];
      mag2_q <= mag1_q;
      qd_q   <= 63'(q0a_q) * 63'(hvd_pkg::SC_DIV);
      num_q  <= {mag2_q, hvd_pkg::SC_HALF};
      q0b_q  <= q0a_q;
      rem_q  <= diff[31:0];
      q0c_q  <= q0b_q;
      quo_q  <= q0c_q + 32'(rem_q >= 32'(hvd_pkg::SC_DIV));
    end
  end

  // ---------------- binary angles and differences ----------------
  logic [31:0] ang_q [4];
  logic        ang_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_vld_q <= 1'b0;
    end else begin
      ang_vld_q <= sc_vld_q[SC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q[0] <= bam[2] - bam[0];
    ang_q[1] <= bam[3] - bam[1];
    ang_q[2] <= bam[0];
    ang_q[3] <= bam[2];
  end

  // ---------------- cosines: dlat, dlon, lat1, lat2 ----------------
  hvd_pkg::cordic_t cin [4];
  hvd_pkg::cordic_t cout [4];

  for (genvar l = 0; l < 4; l++) begin : g_cos
    always_comb begin
      cin[l].valid = ang_vld_q;
      cin[l].flip  = 1'b0;
      cin[l].x     = hvd_pkg::CORD_GAIN;
      cin[l].y     = '0;
      cin[l].z     = W'(ang_q[l]);
    end

    hvd_cordic u_cos (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vect_i (1'b0),
      .in_i   (cin[l]),
      .out_o  (cout[l])
    );
  end

  // ---------------- haversines and the cosine products ----------------
  function automatic logic [30:0] hav_f(input logic signed [W-1:0] c);
    logic signed [W+1:0] h;
    h = ((W+2)'($signed({1'b0, hvd_pkg::ONE_Q30})) - (W+2)'(c)) >>> 1;
    if (h < 0) begin
      return '0;
    end else if (h > (W+2)'($signed({1'b0, hvd_pkg::ONE_Q30}))) begin
      return hvd_pkg::ONE_Q30;
    end else begin
      return h[30:0];
    end
  endfunction

  logic signed [W-1:0] cval [4];
  logic        [30:0]  hlat_q, hlon_q, hlat2_q;
  logic signed [67:0]  p1_q, p2_q;
  logic signed [35:0]  cc;
  logic                sa_vld_q, sb_vld_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      cval[l] = cout[l].flip ? -cout[l].x : cout[l].x;
    end
    cc = 36'(p1_q >>> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
      sb_vld_q <= 1'b0;
    end else begin
      sa_vld_q <= cout[0].valid;
      sb_vld_q <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hlat_q  <= hav_f(cval[0]);
    hlon_q  <= hav_f(cval[1]);
    p1_q    <= cval[2] * cval[3];
    hlat2_q <= hlat_q;
    p2_q    <= cc * $signed({1'b0, hlon_q});
  end

  // ---------------- a, then the two square roots ----------------
  logic signed [38:0] asum;
  logic        [30:0] a_cl;

  always_comb begin
    asum = $signed({8'b0, hlat2_q}) + 39'(p2_q >>> 30);
    if (asum < 0) begin
      a_cl = '0;
    end else if (asum > $signed({8'b0, hvd_pkg::ONE_Q30})) begin
      a_cl = hvd_pkg::ONE_Q30;
    end else begin
      a_cl = asum[30:0];
    end
  end

  logic        sq_vld_q [SQ+1];
  logic [61:0] sq_rad_q [2][SQ+1];
  logic [32:0] sq_rem_q [2][SQ+1];
  logic [30:0] sq_root_q [2][SQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else begin
      sq_vld_q[0] <= sb_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_rad_q[0][0]  <= {1'b0, a_cl, 30'b0};
    sq_rad_q[1][0]  <= {1'b0, 31'(hvd_pkg::ONE_Q30 - a_cl), 30'b0};
    sq_rem_q[0][0]  <= '0;
    sq_rem_q[1][0]  <= '0;
    sq_root_q[0][0] <= '0;
    sq_root_q[1][0] <= '0;
  end

  for (genvar k = 1; k <= SQ; k++) begin : g_sq
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else begin
        sq_vld_q[k] <= sq_vld_q[k-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [34:0] t, trial;

      assign t     = {sq_rem_q[l][k-1], sq_rad_q[l][k-1][61:60]};
      assign trial = {2'b0, sq_root_q[l][k-1], 2'b01};

      // one root bit per stage
      always_ff @(posedge clk_i) begin
        sq_rad_q[l][k] <= {sq_rad_q[l][k-1][59:0], 2'b00};
        if (t >= trial) begin
          sq_rem_q[l][k]  <= 33'(t - trial);
          sq_root_q[l][k] <= {sq_root_q[l][k-1][29:0], 1'b1};
        end else begin
          sq_rem_q[l][k]  <= t[32:0];
          sq_root_q[l][k] <= {sq_root_q[l][k-1][29:0], 1'b0};
        end
      end
    end
  end

  // ---------------- half angle by vectoring ----------------
  hvd_pkg::cordic_t vin, vout;

  always_comb begin
    vin.valid = sq_vld_q[SQ];
    vin.flip  = 1'b0;
    vin.x     = W'(sq_root_q[1][SQ]);
    vin.y     = W'(sq_root_q[0][SQ]);
    vin.z     = '0;
  end

  hvd_cordic u_atan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vect_i (1'b1),
    .in_i   (vin),
    .out_o  (vout)
  );

  // ---------------- scale to metres ----------------
  logic [31:0] t_ang;
  logic [62:0] pm;
  logic [40:0] cq_q;
  logic [43:0] rh_q;
  logic [42:0] rl_q;
  logic [63:0] dsum;
  logic [26:0] dfull;
  logic        pi_vld_q, rm_vld_q, done_q;
  logic [24:0] dist_q;

  always_comb begin
    t_ang = (vout.z < 0) ? 32'd0 : vout.z[31:0];
    pm    = 63'(t_ang) * 63'(hvd_pkg::PI_Q29);
    dsum  = {rh_q, 20'b0} + 64'(rl_q) + (64'd1 << 36);
    dfull = dsum[63:37];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_vld_q <= 1'b0;
      rm_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      pi_vld_q <= vout.valid;
      rm_vld_q <= pi_vld_q;
      done_q   <= rm_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cq_q   <= pm[62:22];
    rh_q   <= 44'(radius_q) * 44'(cq_q[40:20]);
    rl_q   <= 43'(radius_q) * 43'(cq_q[19:0]);
    dist_q <= (dfull > 27'(hvd_pkg::DIST_MAX)) ? hvd_pkg::DIST_MAX : dfull[24:0];
  end

  assign done_o       = done_q;
  assign distance_m_o = dist_q;

  // ---------------- checks ----------------
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##LAT done_o)
    else $error("accepted pair gave no result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |-> ##LAT !done_o)
    else $error("result without an accepted pair");

  a_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (distance_m_o <= hvd_pkg::DIST_MAX))
    else $error("distance above saturation limit");

  a_roots_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q[0] |-> ((32'(sq_rad_q[0][0][60:30]) + 32'(sq_rad_q[1][0][60:30]))
                     == 32'(hvd_pkg::ONE_Q30)))
    else $error("root operands do not sum to one");

endmodule
